>>> hdl/rgb_bilinear_sampler_macros.svh
// assertion macros for the rgb bilinear sampler checker
// expects clk and rst_n in the scope of each use
`ifndef RGB_BILINEAR_SAMPLER_MACROS_SVH
`define RGB_BILINEAR_SAMPLER_MACROS_SVH

// antecedent this edge, consequent at the next edge
`define RGBBS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent at the same edge
`define RGBBS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/rgbbs_pkg.sv
// shared types and constants of the rgb bilinear sampler
// no dependencies
package rgbbs_pkg;

  localparam int DIM_W  = 11;
  localparam int POS_W  = 18;
  localparam int FRAC_W = 8;
  localparam int INT_W  = POS_W - FRAC_W;
  localparam int IDX_W  = 20;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int ROW_W  = 2 * DIM_W;
  localparam int WGT_W  = 17;
  localparam int ACC_W  = 24;
  localparam int LVL_W  = 16;

  // input beat layout
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int IDX_LSB     = 0;
  localparam int RED_LSB     = 20;
  localparam int GRN_LSB     = 28;
  localparam int BLU_LSB     = 36;
  localparam int PX_LSB      = 44;
  localparam int PY_LSB      = 62;
  localparam int TU_CMD      = 0;
  localparam int TU_STREAM   = 1;

  localparam int OUT_TDATA_W = 3 * LVL_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [FRAC_W:0]  FRAC_ONE         = 9'd256;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       rd;
    logic [1:0] nbr;
    logic       acc_en;
    logic       acc_first;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/rgbbs_cfg.sv
// apb configuration registers of the rgb bilinear sampler
// also derives the last pixel index of the frame; uses rgbbs_pkg
module rgbbs_cfg
  import rgbbs_pkg::*;
#(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_AW-1:0]             paddr,
  input  logic [CFG_DW-1:0]             pwdata,
  output logic [CFG_DW-1:0]             prdata,
  output logic                          pready,
  output logic [DIM_W-1:0]              frame_width,
  output logic                          frame_empty,
  output logic [$clog2(MAX_PIXELS)-1:0] last_idx
);

  localparam int IW = $clog2(MAX_PIXELS);

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [IW-1:0]    last_r;
  logic             wr_en;
  logic [ROW_W-1:0] npix;
  logic [31:0]      npix_sat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  width_nxt  = pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_nxt = pwdata[DIM_W-1:0];
        default:          width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // pixel count saturated at the store size, minus one
  assign npix     = ROW_W'(width_r * height_r);
  assign npix_sat = (32'(npix) > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS) : 32'(npix);

  always_ff @(posedge clk) begin
    last_r <= IW'(npix_sat - 32'd1);
  end

  assign prdata      = (paddr[2] == REG_FRAME_HEIGHT) ? CFG_DW'(height_r) : CFG_DW'(width_r);
  assign frame_width = width_r;
  assign frame_empty = (width_r == '0) || (height_r == '0);
  assign last_idx    = last_r;

endmodule

>>> hdl/rgbbs_ctrl.sv
// sequencing controller of the rgb bilinear sampler
// drives the datapath through dp_cmd_t; uses rgbbs_pkg
module rgbbs_ctrl
  import rgbbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_command,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD0  = 7'b0000010,
    S_RD1  = 7'b0000100,
    S_RD2  = 7'b0001000,
    S_RD3  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_command == CMD_SAMPLE) begin
            cmd.load  = 1'b1;
            state_nxt = S_RD0;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_RD0: begin
        cmd.rd    = 1'b1;
        cmd.nbr   = 2'd0;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd        = 1'b1;
        cmd.nbr       = 2'd1;
        cmd.acc_en    = 1'b1;
        cmd.acc_first = 1'b1;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        cmd.rd     = 1'b1;
        cmd.nbr    = 2'd2;
        cmd.acc_en = 1'b1;
        state_nxt  = S_RD3;
      end
      S_RD3: begin
        cmd.rd     = 1'b1;
        cmd.nbr    = 2'd3;
        cmd.acc_en = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // hold here while the output register is still full
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/rgbbs_dp.sv
// datapath of the rgb bilinear sampler: pixel store, index math, blend, output register
// controlled by rgbbs_ctrl through dp_cmd_t; uses rgbbs_pkg
module rgbbs_dp
  import rgbbs_pkg::*;
#(
  parameter int MAX_PIXELS  = 1048576,
  parameter int NUM_STREAMS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  input  logic [IN_TDATA_W-1:0]         in_tdata,
  input  logic [IN_TUSER_W-1:0]         in_tuser,
  input  logic [DIM_W-1:0]              frame_width,
  input  logic                          frame_empty,
  input  logic [$clog2(MAX_PIXELS)-1:0] last_idx,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_TDATA_W-1:0]        out_tdata
);

  localparam int IW    = $clog2(MAX_PIXELS);
  localparam int DEPTH = NUM_STREAMS * MAX_PIXELS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] STREAM1_BASE = AW'(MAX_PIXELS);

  function automatic logic [LVL_W-1:0] to_level(input logic [ACC_W-1:0] acc);
    logic [31:0] s;
    // acc * 257 + half, then drop 16 bits
    s = {acc, 8'b0} + 32'(acc) + 32'd32768;
    return s[31:16];
  endfunction

  // input fields
  logic [IDX_W-1:0] in_idx;
  logic [PIX_W-1:0] in_pix;
  logic [POS_W-1:0] in_px, in_py;
  logic             in_stream;
  logic             in_stream_ok;

  assign in_idx       = in_tdata[IDX_LSB +: IDX_W];
  assign in_pix       = {in_tdata[RED_LSB +: CH_W], in_tdata[GRN_LSB +: CH_W],
                         in_tdata[BLU_LSB +: CH_W]};
  assign in_px        = in_tdata[PX_LSB +: POS_W];
  assign in_py        = in_tdata[PY_LSB +: POS_W];
  assign in_stream    = in_tuser[TU_STREAM];
  assign in_stream_ok = (NUM_STREAMS > 1) || !in_stream;

  // sample context
  logic              stream_r;
  logic              zero_r;
  logic [INT_W-1:0]  xa_r;
  logic [FRAC_W-1:0] fx_r, fy_r;
  logic [DIM_W-1:0]  yb_r;
  logic [ROW_W-1:0]  rowa_r, rowb_r;

  // shared row multiplier: floor row at accept, ceiling row in the first read
  logic [DIM_W-1:0] mul_y;
  logic [ROW_W-1:0] row_prod;

  assign mul_y    = cmd.load ? DIM_W'(in_py[POS_W-1:FRAC_W]) : yb_r;
  assign row_prod = ROW_W'(mul_y * frame_width);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stream_r <= in_stream;
      zero_r   <= !in_stream_ok || frame_empty;
      xa_r     <= in_px[POS_W-1:FRAC_W];
      fx_r     <= in_px[FRAC_W-1:0];
      fy_r     <= in_py[FRAC_W-1:0];
      yb_r     <= DIM_W'(in_py[POS_W-1:FRAC_W]) + DIM_W'(in_py[FRAC_W-1:0] != '0);
      rowa_r   <= row_prod;
    end
    if (cmd.rd && cmd.nbr == 2'd0) begin
      rowb_r <= row_prod;
    end
  end

  // neighbour index, clamped to the last pixel of the frame
  logic [DIM_W-1:0] xb;
  logic [DIM_W-1:0] x_sel;
  logic [ROW_W-1:0] row_sel;
  logic [ROW_W:0]   lin_idx;
  logic [IW-1:0]    rd_idx;
  logic [AW-1:0]    rd_addr, wr_addr, mem_addr;
  logic             wr_ok, mem_we;

  assign xb      = DIM_W'(xa_r) + DIM_W'(fx_r != '0);
  assign x_sel   = cmd.nbr[0] ? xb : DIM_W'(xa_r);
  assign row_sel = cmd.nbr[1] ? rowb_r : rowa_r;
  assign lin_idx = (ROW_W+1)'(row_sel) + (ROW_W+1)'(x_sel);
  assign rd_idx  = (32'(lin_idx) > 32'(last_idx)) ? last_idx : IW'(lin_idx);
  assign rd_addr = (stream_r ? STREAM1_BASE : '0) + AW'(rd_idx);

  assign wr_ok    = in_stream_ok && (32'(in_idx) < 32'(MAX_PIXELS));
  assign wr_addr  = (in_stream ? STREAM1_BASE : '0) + AW'(in_idx);
  assign mem_we   = cmd.wr && wr_ok;
  assign mem_addr = cmd.wr ? wr_addr : rd_addr;

  // single-port pixel store, red in the top byte
  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_addr] <= in_pix;
    end else if (cmd.rd) begin
      rd_data_r <= mem_q[mem_addr];
    end
  end

  // weight of the neighbour being read, registered alongside its pixel
  logic [FRAC_W:0]  gx, gy, wa, wb;
  logic [WGT_W-1:0] w_r;

  assign gx = FRAC_ONE - (FRAC_W+1)'(fx_r);
  assign gy = FRAC_ONE - (FRAC_W+1)'(fy_r);
  assign wa = cmd.nbr[0] ? (FRAC_W+1)'(fx_r) : gx;
  assign wb = cmd.nbr[1] ? (FRAC_W+1)'(fy_r) : gy;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      w_r <= WGT_W'(wa * wb);
    end
  end

  // per-channel accumulate: lane 0 blue, 1 green, 2 red
  logic [ACC_W-1:0] acc_r [3];
  logic [ACC_W-1:0] acc_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = (cmd.acc_first ? '0 : acc_r[c])
                 + ACC_W'(w_r * rd_data_r[c*CH_W +: CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
    end
  end

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign out_data_nxt = zero_r ? '0 : {to_level(acc_r[0]), to_level(acc_r[1]),
                                       to_level(acc_r[2])};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

>>> hdl/rgb_bilinear_sampler.sv
// Bilinear sampler over per-stream RGB frames held in a single-port pixel store.
//
// Input channel (in_*): one beat per item. in_tuser[0] selects the operation:
// a write stores one 24-bit pixel at a linear index of the chosen stream, a
// sample reads the four neighbours of a Q10.8 position and blends them.
// Result channel (out_*): one beat per sample, none per write; each channel
// is scaled so 255 maps to 65535, rounded to nearest.
// Configuration (cfg_*): APB registers frame_width at 0x0, frame_height at 0x4.
// The user writes them only while the block is idle; the block never checks.
//
// Throughput: a write finishes in the cycle it is accepted. A sample steps
// through four reads of the single-port store (RD0..RD3), one per cycle,
// then accumulate (FIN) and output load (OUT); in_tready is low meanwhile.
// When the receiver stalls, the result waits in the output register and the
// next item is still accepted; a following sample holds before its output
// load until that register frees.
// Reset (rst_n, synchronous): clears the sequencer and the output valid and
// restores 640x480; the pixel store is not cleared and needs no sweep.
module rgb_bilinear_sampler
  import rgbbs_pkg::*;
#(
  parameter int MAX_PIXELS  = 1048576,
  parameter int NUM_STREAMS = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pixel_index, pixel_red, pixel_green, pixel_blue, pos_x, pos_y
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command, stream_select
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // red_level, green_level, blue_level
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int IW = $clog2(MAX_PIXELS);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [DIM_W-1:0] frame_width;
  logic             frame_empty;
  logic [IW-1:0]    last_idx;

  rgbbs_cfg #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .frame_width (frame_width),
    .frame_empty (frame_empty),
    .last_idx    (last_idx)
  );

  rgbbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser[TU_CMD]),
    .in_tready  (in_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rgbbs_dp #(
    .MAX_PIXELS  (MAX_PIXELS),
    .NUM_STREAMS (NUM_STREAMS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .frame_width (frame_width),
    .frame_empty (frame_empty),
    .last_idx    (last_idx),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

>>> hdl/rgbbs_chk.sv
// port-level checker for rgb_bilinear_sampler, bound to the top level
// uses rgbbs_pkg and rgb_bilinear_sampler_macros.svh
`include "rgb_bilinear_sampler_macros.svh"

module rgbbs_chk
  import rgbbs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic wr_beat, smp_beat;

  assign wr_beat  = in_tvalid && in_tready && (in_tuser[TU_CMD] == CMD_WRITE);
  assign smp_beat = in_tvalid && in_tready && (in_tuser[TU_CMD] == CMD_SAMPLE);

  `RGBBS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `RGBBS_ASSERT_NEXT(a_write_one_cycle, wr_beat, in_tready, "write beat did not finish in one cycle")
  `RGBBS_ASSERT_NEXT(a_sample_busy, smp_beat, !in_tready, "input taken while a sample is in flight")
  `RGBBS_ASSERT_SAME(a_result_source, $rose(out_tvalid), $past(smp_beat, 7), "result without a sample beat seven cycles earlier")

endmodule

bind rgb_bilinear_sampler rgbbs_chk u_chk (.*);
